FILE: hw/rtl/lpc_pkg.sv
// Shared types, constants and a helper function for the letter pad cipher.
package lpc_pkg;

  localparam int unsigned PadDepthDefault = 256;

  localparam int unsigned ValW   = 5;
  localparam int unsigned LetW   = 7;
  localparam int unsigned CharW  = 8;
  localparam int unsigned StatW  = 2;

  localparam logic [ValW-1:0]  AlphaSize = ValW'(26);
  localparam logic [CharW-1:0] UpperA    = CharW'(65);
  localparam logic [CharW-1:0] LowerA    = CharW'(97);

  localparam logic KindKey = 1'b0;
  localparam logic KindMsg = 1'b1;

  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;

  localparam logic RegMode = 1'b0;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_MSG_LONG = 2'd1,
    ST_KEY_FULL = 2'd2
  } status_e;

  // Word held between the pad read and the combine stage.
  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] value;
  } stage_t;

  // Maps an ASCII letter of either case to 0..25, anything else to 26.
  function automatic logic [ValW-1:0] letter_value(input logic [CharW-1:0] ch);
    logic [CharW-1:0] up;
    logic [CharW-1:0] lo;
    up = ch - UpperA;
    lo = ch - LowerA;
    if (ch >= UpperA && up < CharW'(AlphaSize)) begin
      return up[ValW-1:0];
    end else if (ch >= LowerA && lo < CharW'(AlphaSize)) begin
      return lo[ValW-1:0];
    end else begin
      return AlphaSize;
    end
  endfunction

endpackage

FILE: hw/rtl/lpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lpc_combine.sv
// Mod-26 combine of message letter and pad value, with the output register.
module lpc_combine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     mode_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lpc_pkg::stage_t          in_word_i,
  input  logic [lpc_pkg::ValW-1:0] pad_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [lpc_pkg::LetW-1:0] out_letter_o,
  output lpc_pkg::status_e         out_status_o
);
  import lpc_pkg::*;

  logic              out_valid_q, out_valid_d;
  logic [LetW-1:0]   letter_q, letter_d;
  status_e           status_q, status_d;
  logic              load;
  logic [ValW:0]     sum;
  logic [ValW:0]     diff;
  logic [ValW-1:0]   res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    sum  = {1'b0, in_word_i.value} + {1'b0, pad_i};
    diff = {1'b0, in_word_i.value} - {1'b0, pad_i};
    if (mode_i == ModeEnc) begin
      res = (sum >= {1'b0, AlphaSize}) ? ValW'(sum - {1'b0, AlphaSize}) : sum[ValW-1:0];
    end else begin
      res = (in_word_i.value >= pad_i) ? diff[ValW-1:0]
                                       : ValW'(diff + {1'b0, AlphaSize});
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    letter_d    = letter_q;
    status_d    = status_q;
    if (load) begin
      out_valid_d = 1'b1;
      status_d    = in_word_i.status;
      letter_d    = (in_word_i.status == ST_OK) ? LetW'(UpperA + CharW'(res)) : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
    status_q <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = letter_q;
  assign out_status_o = status_q;

endmodule

FILE: hw/rtl/letter_pad_cipher.sv
// Top level of the letter pad cipher: stream ports, APB register, pad memory.
//
// Characters arrive on the slave stream, one word per ready cycle. tuser selects a
// key character (0) or a message character (1); tdata carries the byte and a
// first flag that starts a new key or rewinds the message position. Key
// letters of either case are stored as 0..25 in the pad memory; message
// letters are combined with the next pad entry (add in encrypt mode, subtract
// in decrypt mode, modulo 26) and give one uppercase letter on the master
// stream. Non-letters give no word. A message letter past the key gives a word
// with status 1; a key letter beyond pad capacity gives a word with status 2.
// The mode register at byte address 0 is written through the APB port.
// A character's value waits in the stage register while the pad memory is read;
// the combine then writes the result word into the output register. One
// character is accepted every cycle while the receiver keeps up. When it stalls,
// the output register and the stage behind it fill and then tready drops.
// Reset clears the key length, message position and mode. The pad memory is
// not cleared; only entries written by the current key are ever read.
module letter_pad_cipher #(
  parameter int unsigned PadDepth = lpc_pkg::PadDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] character, [8] first, rest zero
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] letter, [7] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpc_pkg::*;

  localparam int unsigned CntW  = $clog2(PadDepth + 1);
  localparam int unsigned AddrW = (PadDepth > 1) ? $clog2(PadDepth) : 1;

  logic            mode_q, mode_d;
  logic [CntW-1:0] key_len_q, key_len_d;
  logic [CntW-1:0] msg_pos_q, msg_pos_d;
  logic            s1_valid_q, s1_valid_d;
  stage_t          s1_q, s1_d;

  logic            accept;
  logic            is_key;
  logic            first;
  logic [ValW-1:0] val;
  logic            is_letter;
  logic [CntW-1:0] key_base;
  logic [CntW-1:0] msg_base;
  logic            key_full;
  logic            msg_long;
  logic            ram_we;
  logic            ram_re;
  logic [ValW-1:0] pad_rdata;
  logic            comb_ready;
  logic            cfg_wr;
  logic [LetW-1:0] out_letter;
  status_e         out_status;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegMode);
  assign prdata = (paddr[2] == RegMode) ? {31'd0, mode_q} : '0;
  assign mode_d = cfg_wr ? pwdata[0] : mode_q;

  // Decode of the incoming character.
  assign s_axis_tready = !s1_valid_q || comb_ready;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_key    = (s_axis_tuser == KindKey);
  assign first     = s_axis_tdata[8];
  assign val       = letter_value(s_axis_tdata[CharW-1:0]);
  assign is_letter = (val != AlphaSize);
  assign key_base  = first ? '0 : key_len_q;
  assign msg_base  = first ? '0 : msg_pos_q;
  assign key_full  = (key_base >= CntW'(PadDepth));
  assign msg_long  = (msg_base >= key_len_q);

  assign ram_we = accept && is_key && is_letter && !key_full;
  assign ram_re = accept && !is_key && is_letter && !msg_long;

  // A key write lands before any later message read, so no forwarding is needed.
  lpc_ram #(
    .Width (ValW),
    .Depth (PadDepth)
  ) u_pad_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (key_base[AddrW-1:0]),
    .wdata_i (val),
    .re_i    (ram_re),
    .raddr_i (msg_base[AddrW-1:0]),
    .rdata_o (pad_rdata)
  );

  always_comb begin
    key_len_d  = key_len_q;
    msg_pos_d  = msg_pos_q;
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (accept) begin
      if (is_key) begin
        key_len_d = ram_we ? key_base + CntW'(1) : key_base;
      end else begin
        msg_pos_d = ram_re ? msg_base + CntW'(1) : msg_base;
      end
      s1_valid_d   = is_letter && (!is_key || key_full);
      s1_d.value   = val;
      s1_d.status  = is_key ? ST_KEY_FULL : (msg_long ? ST_MSG_LONG : ST_OK);
    end else if (comb_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeEnc;
      key_len_q  <= '0;
      msg_pos_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      key_len_q  <= key_len_d;
      msg_pos_q  <= msg_pos_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  lpc_combine u_combine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (s1_valid_q),
    .in_ready_o   (comb_ready),
    .in_word_i    (s1_q),
    .pad_i        (pad_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_letter_o (out_letter),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {1'b0, out_letter};
  assign m_axis_tuser = out_status;

  // The key length never passes the pad capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_len_q <= CntW'(PadDepth))
    else $error("key length beyond pad capacity");

  // The pad is read only at entries loaded by the current key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> msg_base < key_len_q)
    else $error("pad read beyond key length");

  // A good result is always an uppercase letter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |->
      m_axis_tdata >= UpperA && m_axis_tdata <= UpperA + CharW'(25))
    else $error("result letter out of range");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the letter pad cipher: directed table, random sessions, scoreboard.
module testbench;
  import lpc_pkg::*;

  localparam int unsigned PadDepth = PadDepthDefault;
  localparam logic [2:0] ModeAddr = 3'(4 * RegMode);
  localparam int unsigned PhaseLetters = 320;

  typedef struct packed {
    logic [LetW-1:0] letter;
    status_e         status;
  } cipher_word_t;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] chr;
    logic             first;
    logic             fixed;
    logic [LetW-1:0]  letter;
    status_e          status;
  } char_row_t;

  // Rows marked fixed carry a result that is known without computing it.
  localparam char_row_t DirectedRows [24] = '{
    '{KindMsg, "A",   1'b1, 1'b1, 7'd0, ST_MSG_LONG},
    '{KindKey, "Z",   1'b1, 1'b0, 7'd0, ST_OK},
    '{KindKey, "a",   1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, 8'h40, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, 8'h5B, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, 8'h60, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, 8'h7B, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, 8'h00, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, 8'hFF, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, "z",   1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, "A",   1'b0, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "A",   1'b1, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "z",   1'b0, 1'b0, 7'd0, ST_OK},
    '{KindMsg, 8'h20, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindMsg, 8'h80, 1'b0, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "Z",   1'b0, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "a",   1'b0, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "b",   1'b0, 1'b1, 7'd0, ST_MSG_LONG},
    '{KindKey, "q",   1'b1, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "c",   1'b0, 1'b1, 7'd0, ST_MSG_LONG},
    '{KindMsg, 8'h21, 1'b1, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "M",   1'b0, 1'b0, 7'd0, ST_OK},
    '{KindKey, 8'h23, 1'b1, 1'b0, 7'd0, ST_OK},
    '{KindMsg, "D",   1'b1, 1'b1, 7'd0, ST_MSG_LONG}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] character, [8] first, rest zero
  logic        s_axis_tuser = 1'b0; // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [6:0] letter, [7] zero
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state.
  logic [ValW-1:0] pad_mem [PadDepth];
  int unsigned     pad_len = 0;
  int unsigned     msg_pos = 0;
  logic            cur_mode = ModeEnc;

  cipher_word_t expected_words [$];
  int unsigned  mismatch_count = 0;
  int unsigned  letters_sent = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  letter_pad_cipher uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [ValW-1:0] alpha_index(input logic [CharW-1:0] ch);
    if (ch >= UpperA && ch < UpperA + CharW'(AlphaSize)) begin
      return ValW'(ch - UpperA);
    end else if (ch >= LowerA && ch < LowerA + CharW'(AlphaSize)) begin
      return ValW'(ch - LowerA);
    end
    return AlphaSize;
  endfunction

  // Advances the predictor by one character and gives the word it causes, if any.
  task automatic predict_char(input logic kind, input logic [CharW-1:0] chr,
                              input logic first, output logic has_word,
                              output cipher_word_t word);
    logic [ValW-1:0] v;
    int unsigned     r;
    v = alpha_index(chr);
    has_word = 1'b0;
    word = '{letter: '0, status: ST_OK};
    if (kind == KindKey) begin
      if (first) pad_len = 0;
      if (v != AlphaSize) begin
        if (pad_len >= PadDepth) begin
          has_word = 1'b1;
          word.status = ST_KEY_FULL;
        end else begin
          pad_mem[pad_len] = v;
          pad_len++;
        end
      end
    end else begin
      if (first) msg_pos = 0;
      if (v != AlphaSize) begin
        has_word = 1'b1;
        if (msg_pos >= pad_len || msg_pos >= PadDepth) begin
          word.status = ST_MSG_LONG;
        end else begin
          if (cur_mode == ModeEnc) begin
            r = (int'(v) + int'(pad_mem[msg_pos])) % 26;
          end else begin
            r = (int'(v) + 26 - int'(pad_mem[msg_pos])) % 26;
          end
          word.letter = LetW'(int'(UpperA) + r);
          msg_pos++;
        end
      end
    end
  endtask

  // Presents one character and waits for it to be taken.
  task automatic push_char(input logic kind, input logic [CharW-1:0] chr,
                           input logic first, input logic fixed,
                           input cipher_word_t fixed_word);
    logic         has_word;
    cipher_word_t word;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, first, chr};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_char(kind, chr, first, has_word, word);
    if (fixed) begin
      expected_words.insert(expected_words.size(), fixed_word);
    end else if (has_word) begin
      expected_words.insert(expected_words.size(), word);
    end
    if (alpha_index(chr) != AlphaSize) letters_sent++;
  endtask

  task automatic send_random(input logic kind, input logic first);
    logic [CharW-1:0] chr;
    if ($urandom_range(99) < 8) begin
      chr = CharW'($urandom_range(255));
    end else begin
      chr = ($urandom_range(1) != 0) ? LowerA : UpperA;
      chr = chr + CharW'($urandom_range(25));
    end
    push_char(kind, chr, first, 1'b0, '0);
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ModeAddr;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cur_mode = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(value)) begin
      $display("%0t: mode read back expected %0d, actual %0d", $time, value, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One key followed by messages against it; a few sessions append to the old
  // key, continue the old message or throw in stray characters.
  task automatic run_session(input int unsigned sess_no);
    logic        long_key;
    int unsigned key_chars;
    int unsigned msg_chars;
    int unsigned n_msgs;
    long_key  = (sess_no % 10 == 3) || ($urandom_range(15) == 0);
    key_chars = long_key ? $urandom_range(250, 262) : $urandom_range(1, 30);
    for (int unsigned i = 0; i < key_chars; i++) begin
      send_random(KindKey, i == 0 && $urandom_range(9) != 0);
    end
    n_msgs = long_key ? 1 : $urandom_range(1, 3);
    for (int unsigned m = 0; m < n_msgs; m++) begin
      msg_chars = $urandom_range(1, key_chars + 3);
      for (int unsigned i = 0; i < msg_chars; i++) begin
        send_random(KindMsg, i == 0 && $urandom_range(9) != 0);
      end
    end
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        push_char(1'($urandom_range(1)), CharW'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cipher_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: expected nothing, actual letter %0d status %0d",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tdata !== 8'(w.letter) || m_axis_tuser !== w.status) begin
          $display("%0t: expected letter %0d status %0d, actual letter %0d status %0d",
                   $time, w.letter, w.status, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned sess_no;
    sess_no = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      push_char(DirectedRows[i].kind, DirectedRows[i].chr, DirectedRows[i].first,
                DirectedRows[i].fixed,
                '{letter: DirectedRows[i].letter, status: DirectedRows[i].status});
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      settle();
      write_mode((phase % 2 == 1) ? ModeDec : ModeEnc);
      letters_sent = 0;
      while (letters_sent < PhaseLetters) begin
        run_session(sess_no);
        sess_no++;
        // Hold the stream once in a while until the pipeline is empty.
        if (sess_no % 7 == 1) settle();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(12 * 800000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
